@@ src/i2r_pkg.sv @@
// ----------------------------------------------------------------------------
// i2r_pkg - shared constants and helpers for integer_to_radix_digits
// Character codes, radix limits, register map and digit encoding.
// ----------------------------------------------------------------------------
package i2r_pkg;

    localparam logic [6:0] CHAR_ZERO     = 7'h30;
    localparam logic [6:0] CHAR_LETTER_A = 7'h41;
    localparam logic [6:0] CHAR_MINUS    = 7'h2D;
    localparam logic [5:0] LETTER_OFFSET = 6'd10;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] BASE_MIN    = 6'd2;
    localparam logic [5:0] BASE_MAX    = 6'd36;

    localparam int         ADDR_W    = 3;
    localparam logic [0:0] REG_RADIX = 1'b0;

    // Clamp the programmed radix into the usable range.
    function automatic logic [5:0] effective_base(input logic [5:0] radix);
        logic [5:0] b;
        b = radix;
        if (b < BASE_MIN) begin
            b = BASE_MIN;
        end
        if (b > BASE_MAX) begin
            b = BASE_MAX;
        end
        return b;
    endfunction

    // Map a digit value to its ASCII code.
    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] c;
        if (d < LETTER_OFFSET) begin
            c = CHAR_ZERO + {1'b0, d};
        end
        else begin
            c = CHAR_LETTER_A + {1'b0, d - LETTER_OFFSET};
        end
        return c;
    endfunction

endpackage

@@ src/integer_to_radix_digits.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits - signed integer to base-N text
// Converts a 32-bit two's complement value to ASCII in base 2..36.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (value, value_valid, value_ready) takes one signed 32-bit
//   item. The output channel (character, last_char, char_valid, char_ready)
//   returns the string one character per item: an optional '-', then the
//   digits most significant first ('0'-'9', 'A'-'Z'); last_char marks the
//   final character. Zero gives the single character '0'.
//   The base comes from the radix register (APB, address 0, reset 10);
//   values below 2 act as 2, above 36 act as 36. Write it only while idle.
// Timing:
//   A shared restoring divider produces one quotient bit per cycle (division
//   never stalls); each digit takes one pass over all 32 dividend bits, and
//   an item has up to MAX_DIGITS digits (32 for base 2). Each character then
//   goes out through the digit buffer (registered read, then output load)
//   once the output register is free, after the '-' for a negative value.
//   value_ready is high only when the sequencer is idle, which includes the
//   time the last character still waits in the output register.
// Reset clears the sequencer and the output register and sets radix to 10.
// A stalled receiver holds the character in the output register and the
// sequencer waits; nothing is dropped.
// ----------------------------------------------------------------------------
module integer_to_radix_digits
    import i2r_pkg::*;
#(
    parameter int MAX_DIGITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input channel
    input  logic signed [31:0]  value,
    input  logic                value_valid,
    output logic                value_ready,
    // output channel
    output logic [6:0]          character,
    output logic                last_char,
    output logic                char_valid,
    input  logic                char_ready
);

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] COUNT_STOP = CW'(MAX_DIGITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUT_SIGN,
        ST_PUT_ZERO,
        ST_RD,
        ST_PUT_DIG
    } state_t;

    state_t          state_reg;
    logic [5:0]      radix_reg;
    logic [31:0]     quot_reg;
    logic [5:0]      rem_reg;
    logic [4:0]      bit_cnt_reg;
    logic [CW-1:0]   count_reg;
    logic            neg_reg;
    logic [IW-1:0]   rd_idx_reg;
    logic [6:0]      char_reg;
    logic            last_reg;
    logic            out_valid_reg;

    // digit buffer, least significant digit first
    logic [5:0]      digit_mem [MAX_DIGITS];
    logic [5:0]      rd_data_reg;

    logic            cfg_write;
    logic            in_accept;
    logic            slot_free;
    logic            out_load;
    logic [5:0]      base;
    logic [6:0]      rem_shift;
    logic            sub_ok;
    logic [5:0]      rem_next;
    logic [31:0]     quot_next;
    logic            digit_done;
    logic            mem_we;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite;
    assign prdata      = (paddr[2] == REG_RADIX) ? {26'd0, radix_reg} : 32'd0;

    assign value_ready = (state_reg == ST_IDLE);
    assign in_accept   = value_valid && value_ready;
    assign slot_free   = !out_valid_reg || char_ready;
    // the sequencer puts a new character into the output register
    assign out_load    = (state_reg inside {ST_PUT_SIGN, ST_PUT_ZERO, ST_PUT_DIG})
                         && slot_free;

    assign character   = char_reg;
    assign last_char   = last_reg;
    assign char_valid  = out_valid_reg;

    // One restoring division step: bring down a dividend bit, try subtracting.
    assign base      = effective_base(radix_reg);
    assign rem_shift = {rem_reg, quot_reg[31]};
    assign sub_ok    = (rem_shift >= {1'b0, base});
    assign rem_next  = sub_ok ? 6'(rem_shift - {1'b0, base}) : rem_shift[5:0];
    assign quot_next = {quot_reg[30:0], sub_ok};

    assign digit_done = (state_reg == ST_DIV) && (bit_cnt_reg == 5'd31);
    assign mem_we     = digit_done;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[count_reg[IW-1:0]] <= rem_next;
        end
        rd_data_reg <= digit_mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            quot_reg      <= '0;
            rem_reg       <= '0;
            bit_cnt_reg   <= '0;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_RADIX))
            begin
                radix_reg <= pwdata[5:0];
            end

            // load a new output item, or drop the held one once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (char_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        neg_reg     <= value[31];
                        quot_reg    <= value[31] ? (32'd0 - value) : value;
                        rem_reg     <= '0;
                        bit_cnt_reg <= '0;
                        count_reg   <= '0;
                        state_reg   <= (value == 32'sd0) ? ST_PUT_ZERO : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    bit_cnt_reg <= bit_cnt_reg + 5'd1;
                    if (digit_done)
                    begin
                        quot_reg  <= quot_next;
                        rem_reg   <= '0;
                        count_reg <= count_reg + 1'b1;
                        if ((quot_next != 32'd0) && (count_reg < COUNT_STOP))
                        begin
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            // most significant digit sits at the old count
                            rd_idx_reg <= count_reg[IW-1:0];
                            state_reg  <= neg_reg ? ST_PUT_SIGN : ST_RD;
                        end
                    end
                    else
                    begin
                        quot_reg <= quot_next;
                        rem_reg  <= rem_next;
                    end
                end
                ST_PUT_SIGN:
                begin
                    if (slot_free)
                    begin
                        char_reg  <= CHAR_MINUS;
                        last_reg  <= 1'b0;
                        state_reg <= ST_RD;
                    end
                end
                ST_PUT_ZERO:
                begin
                    if (slot_free)
                    begin
                        char_reg  <= CHAR_ZERO;
                        last_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RD:
                begin
                    // buffer read of rd_idx_reg lands next cycle
                    state_reg <= ST_PUT_DIG;
                end
                ST_PUT_DIG:
                begin
                    if (slot_free)
                    begin
                        char_reg <= digit_char(rd_data_reg);
                        last_reg <= (rd_idx_reg == '0);
                        if (rd_idx_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg - 1'b1;
                            state_reg  <= ST_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/i2r_checker.sv @@
// ----------------------------------------------------------------------------
// i2r_checker - port-level checks for integer_to_radix_digits
// Watches the channels and flags handshake and character-stream slips.
// ----------------------------------------------------------------------------
module i2r_checker
    import i2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        value_valid,
    input  logic        value_ready,
    input  logic [6:0]  character,
    input  logic        last_char,
    input  logic        char_valid,
    input  logic        char_ready
);

    // a held output item keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(character) && $stable(last_char))
        else $error("output item changed while stalled");

    // conversion is busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && value_ready |=> !value_ready)
        else $error("input accepted twice without conversion");

    // only sign, digits and capital letters appear
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (character == CHAR_MINUS)
            || ((character >= CHAR_ZERO) && (character <= 7'h39))
            || ((character >= CHAR_LETTER_A) && (character <= 7'h5A)))
        else $error("character outside the digit set");

    // the sign is never the final character
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && (character == CHAR_MINUS) |-> !last_char)
        else $error("minus sign marked as last character");

endmodule

bind integer_to_radix_digits i2r_checker u_i2r_checker (.*);
